// ----- rtl/egbw_pkg.sv -----
// Shared types and constants for the Exp-Golomb bit writer.
`default_nettype none

package egbw_pkg;

	localparam logic [2:0] OP_FIXED = 3'd0;
	localparam logic [2:0] OP_UE    = 3'd1;
	localparam logic [2:0] OP_SE    = 3'd2;
	localparam logic [2:0] OP_TRAIL = 3'd3;
	localparam logic [2:0] OP_NAL   = 3'd4;

	localparam logic [23:0] START_CODE  = 24'h000001;
	localparam logic [5:0]  MAX_FIELD_W = 6'd32;
	localparam logic [31:0] CODE_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        align;
		logic [63:0] bits;
		logic [6:0]  nbits;
	} egbw_entry_t;

endpackage

`default_nettype wire

// ----- rtl/exp_golomb_bit_writer.sv -----
// Top level of the MSB-first Exp-Golomb bit writer for H.264 headers.
//
// Input channel (in_valid / in_stall): one beat is one write: a fixed field
// of 0..32 bits, ue(v), se(v), RBSP trailing bits, or start code plus NAL
// header. Output channel (out_valid / out_stall): one beat per completed
// byte, first written bit in bit 7; last marks the final byte of a write.
// Bits that do not complete a byte stay in the partial byte for later writes.
// A write passes through front-end stages s1 and s2, the queue and the
// output byte register. The front end takes one write per cycle unless it
// backs up onto in_stall; the packer emits one byte per cycle unless the
// output stalls. It works through a write byte by byte and leaves bits that
// complete no byte in the partial byte; a write with no bits is dropped in
// the front end and costs the packer nothing. The packer rate sets the
// sustained throughput; the queue absorbs bursts of short writes.
// Reset clears the partial byte, the fill count, the queue and all valids.
// A stalled output beat holds; the packer then stops at its next byte while
// the front end keeps filling the queue until it backs up onto in_stall.
`default_nettype none

module exp_golomb_bit_writer import egbw_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] value,
	input  wire logic [5:0]  field_width,
	input  wire logic [1:0]  ref_idc,
	input  wire logic [4:0]  unit_type,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	egbw_entry_t push_entry;
	egbw_entry_t head;

	egbw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.field_width (field_width),
		.ref_idc     (ref_idc),
		.unit_type   (unit_type),
		.push        (push),
		.push_entry  (push_entry),
		.full        (full)
	);

	egbw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	egbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

`default_nettype wire

// ----- rtl/egbw_front.sv -----
// Front end: accepts writes, maps them to left-aligned bit strings.
`default_nettype none

module egbw_front import egbw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] value,
	input  wire logic [5:0]  field_width,
	input  wire logic [1:0]  ref_idc,
	input  wire logic [4:0]  unit_type,
	output logic             push,
	output egbw_entry_t      push_entry,
	input  wire logic        full
);

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [31:0] value_s1;
	logic [5:0]  width_s1;
	logic [1:0]  ref_idc_s1;
	logic [4:0]  unit_type_s1;

	logic        valid_s2;
	logic        keep_s2;
	logic        align_s2;
	logic        golomb_s2;
	logic [31:0] word_s2;
	logic [5:0]  n_s2;

	logic        ready_s2;
	logic        ready_s1;

	logic        keep_d;
	logic        align_d;
	logic        golomb_d;
	logic [31:0] word_d;
	logic [5:0]  n_d;

	logic [5:0]  len;
	logic [6:0]  nbits;
	logic [6:0]  shamt;

	assign ready_s2 = !valid_s2 || !full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_comb begin
		logic [5:0]  w;
		logic [32:0] mask;
		logic [31:0] mag;
		w        = (width_s1 > MAX_FIELD_W) ? MAX_FIELD_W : width_s1;
		mask     = (33'd1 << w) - 33'd1;
		mag      = ~value_s1 + 32'd1;
		keep_d   = 1'b1;
		align_d  = 1'b0;
		golomb_d = 1'b0;
		word_d   = '0;
		n_d      = '0;
		unique case (op_s1)
			OP_FIXED: begin
				word_d = value_s1 & mask[31:0];
				n_d    = w;
			end
			OP_UE: begin
				golomb_d = 1'b1;
				word_d   = (value_s1 == CODE_MAX) ? CODE_MAX : value_s1 + 32'd1;
			end
			OP_SE: begin
				golomb_d = 1'b1;
				if (value_s1[31]) begin
					word_d = mag[31] ? CODE_MAX : {mag[30:0], 1'b1};
				end else if (value_s1 == 32'd0) begin
					word_d = 32'd1;
				end else begin
					word_d = {value_s1[30:0], 1'b0};
				end
			end
			OP_TRAIL: begin
				align_d = 1'b1;
			end
			OP_NAL: begin
				word_d = {START_CODE, 1'b0, ref_idc_s1, unit_type_s1};
				n_d    = MAX_FIELD_W;
			end
			default: begin
				keep_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			op_s1        <= op;
			value_s1     <= value;
			width_s1     <= field_width;
			ref_idc_s1   <= ref_idc;
			unit_type_s1 <= unit_type;
		end
		if (ready_s2 && valid_s1) begin
			keep_s2   <= keep_d;
			align_s2  <= align_d;
			golomb_s2 <= golomb_d;
			word_s2   <= word_d;
			n_s2      <= n_d;
		end
	end

	always_comb begin
		len = 6'd1;
		for (int i = 0; i < 32; i++) begin
			if (word_s2[i]) begin
				len = 6'(i + 1);
			end
		end
	end

	assign nbits = golomb_s2 ? ({len, 1'b0} - 7'd1) : {1'b0, n_s2};
	assign shamt = 7'd64 - nbits;

	assign push_entry.align = align_s2;
	assign push_entry.bits  = {32'd0, word_s2} << shamt[5:0];
	assign push_entry.nbits = nbits;
	assign push = valid_s2 && !full && keep_s2 && (align_s2 || nbits != 7'd0);

endmodule

`default_nettype wire

// ----- rtl/egbw_queue.sv -----
// Short queue of bit-string entries between the front and back ends.
`default_nettype none

module egbw_queue import egbw_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire egbw_entry_t  push_entry,
	output logic              full,
	input  wire logic         pop,
	output egbw_entry_t       head,
	output logic              empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	egbw_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/egbw_back.sv -----
// Back end: packs queued bit strings into bytes and drives the output beat.
`default_nettype none

module egbw_back import egbw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire egbw_entry_t head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic [7:0]  part_q;
	logic [2:0]  fill_q;
	logic        active_q;
	logic [63:0] work_bits_q;
	logic [6:0]  work_nbits_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic        have;
	logic        cur_align;
	logic [63:0] cur_bits;
	logic [6:0]  cur_nbits;
	logic [3:0]  space;
	logic [3:0]  k;
	logic [3:0]  nfill;
	logic [6:0]  rem_next;
	logic [7:0]  merged;
	logic [7:0]  emit_byte;
	logic        emit;
	logic        emit_last;
	logic        done;
	logic        out_ok;
	logic        go;

	assign have      = active_q || !empty;
	assign cur_align = !active_q && head.align;
	assign cur_bits  = active_q ? work_bits_q : head.bits;
	assign cur_nbits = active_q ? work_nbits_q : head.nbits;

	assign space    = 4'd8 - {1'b0, fill_q};
	assign k        = (cur_nbits < {3'd0, space}) ? cur_nbits[3:0] : space;
	assign nfill    = {1'b0, fill_q} + k;
	assign rem_next = cur_nbits - {3'd0, k};
	assign merged   = part_q | (cur_bits[63:56] >> fill_q);

	always_comb begin
		if (cur_align) begin
			emit_byte = part_q | (8'h80 >> fill_q);
			emit      = 1'b1;
			emit_last = 1'b1;
			done      = 1'b1;
		end else begin
			emit_byte = merged;
			emit      = (nfill == 4'd8);
			emit_last = (rem_next < 7'd8);
			done      = (rem_next == 7'd0);
		end
	end

	assign out_ok = !out_valid_q || !out_stall;
	assign go     = have && (!emit || out_ok);
	assign pop    = go && !active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q      <= '0;
			fill_q      <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				part_q   <= emit ? 8'd0 : merged;
				fill_q   <= emit ? 3'd0 : nfill[2:0];
				active_q <= !done;
			end
			if (out_ok) begin
				out_valid_q <= go && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !done) begin
			work_bits_q  <= cur_bits << k;
			work_nbits_q <= rem_next;
		end
		if (go && emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	a_work_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> work_nbits_q != 7'd0) else $error("active entry with no bits");
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit) |=> out_valid_q) else $error("emitted byte not presented");

endmodule

`default_nettype wire
